/* hw/rtl/plt_pkg.sv */
`timescale 1ns / 1ps
// Package for the positional list table: request and status codes, job descriptor type
// and parameter defaults. No dependencies.
package plt_pkg;

  // Parameter defaults
  localparam int unsigned MAX_LEN_DEF    = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FPOS_W   = 6;
  localparam int unsigned LEN_W    = 7;

  // Request kinds
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOCATE = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  // Work the sequencer runs for one request
  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_INS,
    JOB_DEL,
    JOB_GET,
    JOB_LOC
  } job_e;

  typedef struct packed {
    job_e                kind;
    logic [STATUS_W-1:0] status;
    logic                walk;   // insert only: later entries must move up
  } job_t;

endpackage

/* hw/rtl/plt_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on plt_pkg for parameter defaults.
module plt_ram import plt_pkg::*; #(
  parameter int unsigned WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned DEPTH = MAX_LEN_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/plt_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the positional list table: walks the element RAM one entry per cycle
// with one shared address stepper and one equality compare. Depends on plt_pkg.
module plt_ctrl import plt_pkg::*; #(
  parameter int unsigned MAX_LEN    = MAX_LEN_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(MAX_LEN),
  localparam int unsigned CW        = $clog2(MAX_LEN + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  job_t                  job_i,
  input  logic [AW-1:0]         first_i,
  input  logic [AW-1:0]         stop_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [AW-1:0]         fpos_o,
  output logic                  found_o,
  output logic [CW-1:0]         count_o,
  output logic                  ram_we_o,
  output logic [AW-1:0]         ram_waddr_o,
  output logic [DATA_WIDTH-1:0] ram_wdata_o,
  output logic                  ram_re_o,
  output logic [AW-1:0]         ram_raddr_o,
  input  logic [DATA_WIDTH-1:0] ram_rdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PUT
  } state_e;

  state_e                state_q;
  job_e                  kind_q;
  logic [STATUS_W-1:0]   status_q;
  logic [AW-1:0]         ptr_q;    // next read address
  logic [AW-1:0]         last_q;   // address of the read in flight
  logic [AW-1:0]         stop_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [AW-1:0]         fpos_q;
  logic                  found_q;
  logic [CW-1:0]         count_q;
  logic                  done_q;
  logic                  more_q;   // reads still to issue
  logic                  pend_q;   // read data arrives this cycle
  logic                  head_q;   // first arriving word of the walk
  logic                  match;

  assign match = (ram_rdata_i == val_q);

  // RAM port control
  always_comb begin
    ram_re_o    = (state_q == ST_WALK) && more_q;
    ram_raddr_o = ptr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = last_q;
    ram_wdata_o = ram_rdata_i;
    case (state_q)
      ST_WALK: begin
        if (pend_q) begin
          if (kind_q == JOB_INS) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = last_q + AW'(1);
          end else if ((kind_q == JOB_DEL) && !head_q) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = last_q - AW'(1);
          end
        end
      end
      ST_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = stop_q;
        ram_wdata_o = val_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= JOB_NONE;
      count_q <= '0;
      done_q  <= 1'b0;
      more_q  <= 1'b0;
      pend_q  <= 1'b0;
      head_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            kind_q   <= job_i.kind;
            status_q <= job_i.status;
            ptr_q    <= first_i;
            stop_q   <= stop_i;
            val_q    <= value_i;
            data_q   <= '0;
            fpos_q   <= '0;
            found_q  <= 1'b0;
            pend_q   <= 1'b0;
            more_q   <= 1'b1;
            head_q   <= 1'b1;
            case (job_i.kind)
              JOB_NONE: done_q  <= 1'b1;
              JOB_INS:  state_q <= job_i.walk ? ST_WALK : ST_PUT;
              default:  state_q <= ST_WALK;
            endcase
          end
        end
        ST_WALK: begin
          // Issue the next read and step the pointer
          pend_q <= more_q;
          if (more_q) begin
            last_q <= ptr_q;
            if (ptr_q == stop_q) begin
              more_q <= 1'b0;
            end else if (kind_q == JOB_INS) begin
              ptr_q <= ptr_q - AW'(1);
            end else begin
              ptr_q <= ptr_q + AW'(1);
            end
          end
          // Consume the word that arrives
          if (pend_q) begin
            head_q <= 1'b0;
            case (kind_q)
              JOB_DEL: begin
                if (head_q) begin
                  data_q <= ram_rdata_i;
                end
              end
              JOB_GET: data_q <= ram_rdata_i;
              JOB_LOC: begin
                if (match) begin
                  found_q <= 1'b1;
                  fpos_q  <= last_q;
                  done_q  <= 1'b1;
                  state_q <= ST_IDLE;
                end
              end
              default: ;
            endcase
            if (!more_q) begin
              case (kind_q)
                JOB_INS: state_q <= ST_PUT;
                JOB_DEL: begin
                  count_q <= count_q - CW'(1);
                  done_q  <= 1'b1;
                  state_q <= ST_IDLE;
                end
                default: begin
                  done_q  <= 1'b1;
                  state_q <= ST_IDLE;
                end
              endcase
            end
          end
        end
        ST_PUT: begin
          count_q <= count_q + CW'(1);
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign data_o   = data_q;
  assign fpos_o   = fpos_q;
  assign found_o  = found_q;
  assign count_o  = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_LEN))
    else $error("element count above capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o && (ram_waddr_o == ram_raddr_o)))
    else $error("RAM read and write hit the same entry");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while sequencer busy");

  a_count_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> done_q)
    else $error("element count changed without a result");

endmodule

/* hw/rtl/positional_list_table.sv */
`timescale 1ns / 1ps
// Top level of the positional list table: request checks, element RAM and sequencer.
// Depends on plt_pkg, plt_ram and plt_ctrl.
//
//   channel   direction  handshake                 payload
//   request   in         start & !busy             func, position, value
//   result    out        done_o, one cycle strobe  status_o, data_out_o, found_pos_o,
//                                                  found_o, list_length_o
//
// Flow: one request at a time; busy is high from the accept edge until the edge that
// raises done_o. For a rejected request or a locate on an empty list the accept edge
// raises done_o and busy stays low. Get reads one entry; delete returns the entry at
// the position and moves each later entry down one place; insert moves the entries
// from the position on up one place, then writes the value; locate stops at a match.
// While walking, the element RAM takes up to one read and one write per cycle.
// Reset clears the count; RAM entries are never read before being written.
// The receiver cannot stall: each result stays on its outputs until the next request is
// accepted, and a new request may be accepted in the strobe cycle.
module positional_list_table import plt_pkg::*; #(
  parameter int unsigned MAX_LEN    = MAX_LEN_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic [VALUE_W-1:0]  value_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [VALUE_W-1:0]  data_out_o,
  output logic [FPOS_W-1:0]   found_pos_o,
  output logic                found_o,
  output logic [LEN_W-1:0]    list_length_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  // common width for comparing a request position with the count
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  job_t                  job;
  logic [AW-1:0]         first_addr;
  logic [AW-1:0]         stop_addr;
  logic [DATA_WIDTH-1:0] value_int;
  logic [CW-1:0]         count;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         cnt_w;
  logic [STATUS_W-1:0]   status_int;
  logic [DATA_WIDTH-1:0] data_int;
  logic [AW-1:0]         fpos_int;
  logic                  found_int;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign value_int = DATA_WIDTH'(value_i);
  assign pos_w     = PW'(position_i);
  assign cnt_w     = PW'(count);

  // Check the request against the current length and the capacity and pick the walk bounds.
  // Insert walks from the tail down to the position (no walk at the end of the list),
  // delete from the position up to the tail, get reads one entry, locate scans from the head.
  always_comb begin
    job.kind   = JOB_NONE;
    job.status = STATUS_OK;
    job.walk   = 1'b0;
    first_addr = '0;
    stop_addr  = '0;
    case (func_i)
      FUNC_INSERT: begin
        if (pos_w > cnt_w) begin
          job.status = STATUS_BAD_POS;
        end else if (cnt_w == PW'(MAX_LEN)) begin
          job.status = STATUS_FULL;
        end else begin
          job.kind   = JOB_INS;
          job.walk   = (pos_w != cnt_w);
          first_addr = AW'(cnt_w - PW'(1));
          stop_addr  = AW'(pos_w);
        end
      end
      FUNC_DELETE: begin
        if (pos_w >= cnt_w) begin
          job.status = STATUS_BAD_POS;
        end else begin
          job.kind   = JOB_DEL;
          first_addr = AW'(pos_w);
          stop_addr  = AW'(cnt_w - PW'(1));
        end
      end
      FUNC_GET: begin
        if ((pos_w == '0) || (pos_w > cnt_w)) begin
          job.status = STATUS_BAD_POS;
        end else begin
          job.kind   = JOB_GET;
          first_addr = AW'(pos_w - PW'(1));
          stop_addr  = AW'(pos_w - PW'(1));
        end
      end
      FUNC_LOCATE: begin
        // empty list: answer not-found at once
        if (cnt_w != '0) begin
          job.kind  = JOB_LOC;
          stop_addr = AW'(cnt_w - PW'(1));
        end
      end
      default: ;
    endcase
  end

  plt_ctrl #(
    .MAX_LEN    (MAX_LEN),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .job_i       (job),
    .first_i     (first_addr),
    .stop_i      (stop_addr),
    .value_i     (value_int),
    .busy_o      (busy),
    .done_o      (done_o),
    .status_o    (status_int),
    .data_o      (data_int),
    .fpos_o      (fpos_int),
    .found_o     (found_int),
    .count_o     (count),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Element store
  plt_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Fit internal widths to the result fields
  assign status_o      = status_int;
  assign data_out_o    = VALUE_W'(data_int);
  assign found_pos_o   = FPOS_W'(fpos_int);
  assign found_o       = found_int;
  assign list_length_o = LEN_W'(count);

endmodule
